[design/tcepc_pkg.sv]
// Shared types and constants for the three-channel echo pulse capture block.
`timescale 1ns / 1ps
`default_nettype none

package tcepc_pkg;

    localparam int CHANNELS        = 3;
    localparam int READ_W          = 16;
    localparam int LEVEL_W         = 3;
    localparam int DEF_COUNT_BITS  = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [READ_W-1:0] ERROR_CODE       = 16'd65355;
    localparam logic [READ_W-1:0] READ_SAT         = 16'hFFFF;
    localparam logic [READ_W-1:0] MAX_VALID_RST    = 16'd4370;
    localparam logic [READ_W-1:0] FRAME_PERIOD_RST = 16'd7500;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALID    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD = 2'd1;

    typedef logic [READ_W-1:0] reading_t;

    typedef struct packed {
        reading_t [CHANNELS-1:0] readings;
        logic                    frame_start;
    } result_t;

endpackage

`default_nettype wire

[design/tcepc_core.sv]
// Frame counter, edge capture, pending and published readings for three channels.
`timescale 1ns / 1ps
`default_nettype none

module tcepc_core
    import tcepc_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [LEVEL_W-1:0]     levels,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output result_t                     result
);

    localparam int CMP_W = (COUNT_BITS > READ_W) ? COUNT_BITS : READ_W;

    logic [READ_W-1:0]                     max_valid_reg;
    logic [READ_W-1:0]                     frame_period_reg;
    logic [COUNT_BITS-1:0]                 tick_count_reg;
    logic [COUNT_BITS-1:0]                 tick_count_next;
    logic [LEVEL_W-1:0]                    prior_levels_reg;
    logic [LEVEL_W-1:0]                    prior_levels_next;
    logic [CHANNELS-1:0][COUNT_BITS-1:0]   start_reg;
    logic [CHANNELS-1:0][COUNT_BITS-1:0]   start_next;
    reading_t [CHANNELS-1:0]               pending_reg;
    reading_t [CHANNELS-1:0]               pending_next;
    reading_t [CHANNELS-1:0]               published_reg;
    reading_t [CHANNELS-1:0]               published_next;

    logic                  frame_end;
    logic [LEVEL_W-1:0]    rising;
    logic [LEVEL_W-1:0]    falling;
    logic [CMP_W-1:0]      diff [CHANNELS];
    reading_t              fixed [CHANNELS];

    assign frame_end = CMP_W'(tick_count_reg) >= CMP_W'(frame_period_reg);
    assign rising    = levels & ~prior_levels_reg;
    assign falling   = prior_levels_reg & ~levels;

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        prior_levels_next = prior_levels_reg;
        start_next        = start_reg;
        pending_next      = pending_reg;
        published_next    = published_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            diff[i]  = CMP_W'(tick_count_reg - start_reg[i]);
            fixed[i] = ((pending_reg[i] == '0) || (pending_reg[i] >= max_valid_reg))
                       ? ERROR_CODE : pending_reg[i];
        end
        if (frame_end)
        begin
            // publish, retrigger, keep prior levels
            for (int i = 0; i < CHANNELS; i++)
            begin
                pending_next[i]   = fixed[i];
                published_next[i] = fixed[i];
            end
            tick_count_next = '0;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (rising[i])
                begin
                    start_next[i] = tick_count_reg;
                end
                if (falling[i])
                begin
                    if (tick_count_reg < start_reg[i])
                    begin
                        pending_next[i] = ERROR_CODE;
                    end
                    else if (diff[i] > CMP_W'(READ_SAT))
                    begin
                        pending_next[i] = READ_SAT;
                    end
                    else
                    begin
                        pending_next[i] = diff[i][READ_W-1:0];
                    end
                end
            end
            prior_levels_next = levels;
            tick_count_next   = tick_count_reg + COUNT_BITS'(1);
        end
        result.readings    = published_next;
        result.frame_start = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_valid_reg    <= MAX_VALID_RST;
            frame_period_reg <= FRAME_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_VALID:    max_valid_reg    <= cfg_data;
                REG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            prior_levels_reg <= '0;
            start_reg        <= '0;
            pending_reg      <= '0;
            published_reg    <= '0;
        end
        else if (accept)
        begin
            tick_count_reg   <= tick_count_next;
            prior_levels_reg <= prior_levels_next;
            start_reg        <= start_next;
            pending_reg      <= pending_next;
            published_reg    <= published_next;
        end
    end

    a_frame_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> tick_count_reg == '0)
        else $error("tick count not cleared at frame end");

    a_frame_end_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_end |=> $stable(prior_levels_reg))
        else $error("prior levels changed on frame end tick");

    a_idle_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(tick_count_reg) && $stable(published_reg))
        else $error("state advanced without an accepted beat");

endmodule

`default_nettype wire

[design/tcepc_out_buf.sv]
// Output register with skid stage for result beats.
`timescale 1ns / 1ps
`default_nettype none

module tcepc_out_buf
    import tcepc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  result_t   push_data,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_stall,
    output result_t   out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // drain the skid stage first to keep beat order
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while output is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("beat pushed into a full buffer");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("skid stage did not drain on pop");

endmodule

`default_nettype wire

[design/three_channel_echo_pulse_capture.sv]
// Three-channel echo pulse capture: top level.
// Each input beat on in_valid/in_stall is one prescaled timer tick carrying
// the three echo pin levels in echo_levels (bit n is channel n). Every input
// beat yields exactly one output beat on out_valid/out_stall with the
// published readings reading_a..reading_c and frame_start.
// A free-running frame counter advances per tick; rising edges record the
// start count, falling edges store the pulse length as pending. When the
// counter reaches frame_period the tick ignores the levels, maps zero or
// out-of-range pending readings to 65355, publishes them and raises
// frame_start. max_valid and frame_period are written on the cfg channel
// (index 0 and 1); the user must write them only while the block is idle,
// which the block itself does not enforce; cfg_ready is always high.
// Throughput: one beat per cycle while in_stall is low; results are registered.
// When the receiver stalls, the output register holds its beat and a skid
// stage takes one more; in_stall rises only while the skid stage is full.
// Reset clears the counter, captured edges, pending and published readings
// and loads max_valid = 4370 and frame_period = 7500.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_echo_pulse_capture
    import tcepc_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [LEVEL_W-1:0]     echo_levels,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [READ_W-1:0]           reading_a,
    output logic [READ_W-1:0]           reading_b,
    output logic [READ_W-1:0]           reading_c,
    output logic                        frame_start,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    accept;
    logic    full;
    result_t core_result;
    result_t out_result;

    assign in_stall  = full;
    assign accept    = in_valid && !full;
    assign cfg_ready = 1'b1;

    tcepc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .levels    (echo_levels),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (core_result)
    );

    tcepc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign reading_a   = out_result.readings[0];
    assign reading_b   = out_result.readings[1];
    assign reading_c   = out_result.readings[2];
    assign frame_start = out_result.frame_start;

endmodule

`default_nettype wire

[tb/three_channel_echo_pulse_capture_tb.sv]
// Testbench for the three-channel echo pulse capture block: random and directed ticks checked against a predictor.
`timescale 1ns / 1ps

module three_channel_echo_pulse_capture_tb;

    import tcepc_pkg::*;

    localparam int COUNT_BITS = DEF_COUNT_BITS;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [LEVEL_W-1:0]     echo_levels = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [READ_W-1:0]      reading_a;
    logic [READ_W-1:0]      reading_b;
    logic [READ_W-1:0]      reading_c;
    logic                   frame_start;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    three_channel_echo_pulse_capture i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .echo_levels (echo_levels),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reading_a   (reading_a),
        .reading_b   (reading_b),
        .reading_c   (reading_c),
        .frame_start (frame_start),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [READ_W-1:0]     limit_len = MAX_VALID_RST;
    logic [READ_W-1:0]     frame_len = FRAME_PERIOD_RST;
    logic [COUNT_BITS-1:0] frame_count = '0;
    logic [LEVEL_W-1:0]    last_levels = '0;
    logic [COUNT_BITS-1:0] rise_time [CHANNELS] = '{default: '0};
    reading_t              pending_len [CHANNELS] = '{default: '0};
    reading_t              shown_len [CHANNELS] = '{default: '0};

    logic [LEVEL_W-1:0] ticks_pending [$];
    result_t            readings_due [$];
    int                 mismatches = 0;

    // sender bursts and gaps
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall pattern and long hold-off
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    logic [7:0]  stall_mask = 8'h00;
    logic        stall_now;
    logic        hold_arm = 1'b0;
    logic        hold_on = 1'b0;
    int          hold_count = 0;

    // stimulus generation
    logic [LEVEL_W-1:0] gen_levels = '0;
    int                 phase_max_valid;
    int                 phase_frame;

    task automatic capture_tick(input logic [LEVEL_W-1:0] lv);
        result_t             r;
        logic [LEVEL_W-1:0]  rise;
        logic [LEVEL_W-1:0]  fall;
        logic [COUNT_BITS:0] span;
        r.frame_start = 1'b0;
        if (frame_count >= frame_len)
        begin
            // frame end: levels ignored, publish and restart
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (pending_len[c] == '0 || pending_len[c] >= limit_len)
                    pending_len[c] = ERROR_CODE;
                shown_len[c] = pending_len[c];
            end
            frame_count = '0;
            r.frame_start = 1'b1;
        end
        else
        begin
            rise = lv & ~last_levels;
            fall = last_levels & ~lv;
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (rise[c])
                    rise_time[c] = frame_count;
                if (fall[c])
                begin
                    if (frame_count < rise_time[c])
                        pending_len[c] = ERROR_CODE;
                    else
                    begin
                        span = {1'b0, frame_count} - {1'b0, rise_time[c]};
                        pending_len[c] = (span > READ_SAT) ? READ_SAT : span[READ_W-1:0];
                    end
                end
            end
            last_levels = lv;
            frame_count = frame_count + COUNT_BITS'(1);
        end
        for (int c = 0; c < CHANNELS; c++)
            r.readings[c] = shown_len[c];
        readings_due.push_back(r);
    endtask

    // Driver: predict on each accepted beat, hold a stalled beat, else serve bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                capture_tick(echo_levels);
            if (!(in_valid && in_stall))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (burst_left > 0 && ticks_pending.size() > 0)
                begin
                    in_valid <= 1'b1;
                    echo_levels <= ticks_pending.pop_front();
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Long receiver hold-off, armed from the stimulus process.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_arm && !hold_on)
        begin
            hold_on <= 1'b1;
            hold_count <= HOLD_CYCLES;
        end
        else if (hold_on)
        begin
            if (hold_count == 1)
                hold_on <= 1'b0;
            hold_count <= hold_count - 1;
        end
    end

    // Monitor: check each accepted result beat, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, readings %0d %0d %0d frame_start %0b",
                             $time, reading_a, reading_b, reading_c, frame_start);
                    mismatches++;
                end
                else
                begin
                    result_t                 exp;
                    reading_t [CHANNELS-1:0] seen;
                    exp = readings_due.pop_front();
                    seen = {reading_c, reading_b, reading_a};
                    for (int c = 0; c < CHANNELS; c++)
                        if (seen[c] !== exp.readings[c])
                        begin
                            $display("%0t: channel %0d reading expected %0d, got %0d",
                                     $time, c, exp.readings[c], seen[c]);
                            mismatches++;
                        end
                    if (frame_start !== exp.frame_start)
                    begin
                        $display("%0t: frame_start expected %0b, got %0b",
                                 $time, exp.frame_start, frame_start);
                        mismatches++;
                    end
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
                stall_mask = 8'($urandom);
            end
            mode_left--;
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            case (stall_mode)
                STALL_NONE:  stall_now = 1'b0;
                STALL_LIGHT: stall_now = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: stall_now = ($urandom_range(0, 9) < 6);
                default:     stall_now = stall_mask[0];
            endcase
            out_stall <= stall_now || hold_on;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAX_VALID)
            limit_len = val;
        else if (idx == REG_FRAME_PERIOD)
            frame_len = val;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mv, input logic [CFG_DATA_W-1:0] fp);
        write_reg(REG_MAX_VALID, mv);
        write_reg(REG_FRAME_PERIOD, fp);
    endtask

    // Wait until every tick is taken and every result checked, then let the pipe empty.
    task automatic settle();
        while (ticks_pending.size() != 0 || in_valid || readings_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Channels toggle with odds 1/flip_den per tick; noise_pct percent are random levels.
    task automatic queue_ticks(input int n, input int flip_den, input int noise_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                gen_levels = LEVEL_W'($urandom_range(0, 7));
            else
                for (int c = 0; c < CHANNELS; c++)
                    if ($urandom_range(0, flip_den - 1) == 0)
                        gen_levels[c] = ~gen_levels[c];
            ticks_pending.push_back(gen_levels);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: captures run, nothing publishes inside the default frame
        queue_ticks(150, 20, 2);
        settle();

        // tiny frame: short pulses, zero length, pending kept, pulses across frames
        set_config(16'd5, 16'd6);
        foreach (gen_levels[c])
            gen_levels[c] = 1'b0;
        begin
            logic [LEVEL_W-1:0] directed [24];
            directed = '{3'd0, 3'd7, 3'd6, 3'd4, 3'd4, 3'd0, 3'd7, 3'd7, 3'd3, 3'd3,
                         3'd3, 3'd3, 3'd3, 3'd7, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
                         3'd5, 3'd0, 3'd2, 3'd2};
            foreach (directed[k])
                ticks_pending.push_back(directed[k]);
        end
        settle();

        // every reading invalid
        set_config(16'd0, 16'd4);
        queue_ticks(40, 2, 20);
        settle();

        // publish on every tick
        set_config(16'd10, 16'd0);
        queue_ticks(30, 2, 20);
        settle();

        set_config(16'd1, 16'd1);
        queue_ticks(40, 2, 20);
        settle();

        // widest frame and limit: captures without a frame end
        set_config(16'hFFFF, 16'hFFFF);
        queue_ticks(50, 10, 0);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 3))
                0:       phase_max_valid = $urandom_range(1, 4);
                1:       phase_max_valid = $urandom_range(5, 40);
                2:       phase_max_valid = 65535;
                default: phase_max_valid = $urandom_range(1, 65535);
            endcase
            phase_frame = ($urandom_range(0, 7) == 0) ? $urandom_range(51, 65535)
                                                       : $urandom_range(1, 50);
            set_config(phase_max_valid[CFG_DATA_W-1:0], phase_frame[CFG_DATA_W-1:0]);
            queue_ticks(150, $urandom_range(2, 12), 10);
            if (p == 3)
            begin
                // hold the receiver off so the block backs up into its input
                hold_arm <= 1'b1;
                wait (hold_on);
                hold_arm <= 1'b0;
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #48_000_000;
        $display("timeout: %0d ticks queued, %0d results outstanding",
                 ticks_pending.size(), readings_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/tcepc_pkg.sv
design/tcepc_core.sv
design/tcepc_out_buf.sv
design/three_channel_echo_pulse_capture.sv
tb/three_channel_echo_pulse_capture_tb.sv
